// ===== sv/scanline_span_extent_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// Scanline span extent table: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_SPAN_EXTENT_TABLE_CORE_MACROS_SVH
`define SCANLINE_SPAN_EXTENT_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SPEXT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPEXT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spext_pkg.sv =====
// ----------------------------------------------------------------------------
// Scanline span extent table: package
// Defaults, register indexes and item operation codes.
// ----------------------------------------------------------------------------
package spext_pkg;

    localparam int ROWS_DEFAULT       = 1024;
    localparam int COORD_BITS_DEFAULT = 16;
    localparam int ROW_LAST_RESET     = 1023;

    // configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_FIRST = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_LAST  = 2'd1;

    // item operations
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

endpackage

// ===== sv/scanline_span_extent_table_core.sv =====
// ----------------------------------------------------------------------------
// Scanline span extent table core
// Per-row start/end column store for rasterization, with row extent tracking.
//
//   channel   handshake                 payload
//   -------   -----------------------   --------------------------------------
//   item in   start & !busy             op, x, y
//   result    done (one cycle)          in_range, row_valid, span_start,
//                                       span_end, near_span, lowest_row,
//                                       highest_row, single_row
//   config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One item per cycle while busy is low; its result shows on done after the
// update stage and the result registers. The row store is one memory with a
// registered read port: read at accept, modify and write back in the next cycle, a same-row write forwarded.
// After reset a clearing pass zeroes every row of the store with busy high;
// configuration writes are taken throughout. Results cannot be stalled.
// ----------------------------------------------------------------------------
module scanline_span_extent_table_core #(
    parameter int ROWS       = spext_pkg::ROWS_DEFAULT,
    parameter int COORD_BITS = spext_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 op,
    input  logic signed [COORD_BITS-1:0]         x,
    input  logic signed [COORD_BITS-1:0]         y,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spext_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    output logic                                 done,
    output logic                                 in_range,
    output logic                                 row_valid,
    output logic signed [COORD_BITS-1:0]         span_start,
    output logic signed [COORD_BITS-1:0]         span_end,
    output logic                                 near_span,
    output logic signed [COORD_BITS-1:0]         lowest_row,
    output logic signed [COORD_BITS-1:0]         highest_row,
    output logic                                 single_row
);
    import spext_pkg::*;

    localparam int AW = $clog2(ROWS);
    localparam int DW = 2 * COORD_BITS + 1;
    localparam int CW = COORD_BITS + 18;

    // configuration
    logic signed [COORD_BITS-1:0] row_first_reg;
    logic signed [COORD_BITS-1:0] row_last_reg;

    // clearing pass
    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;

    // row store: {seen, start, end}
    logic [DW-1:0] mem [ROWS];
    logic [DW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;

    // accept stage
    logic                       acc;
    logic signed [COORD_BITS:0] diff;
    logic [CW-1:0]              diff_w;
    logic                       row_ok;
    logic [AW-1:0]              addr;

    // update stage
    logic                         s1_valid_reg;
    logic                         s1_op_reg;
    logic signed [COORD_BITS-1:0] s1_x_reg;
    logic signed [COORD_BITS-1:0] s1_y_reg;
    logic                         s1_ok_reg;
    logic [AW-1:0]                s1_addr_reg;
    logic                         fwd_reg;
    logic [DW-1:0]                fwd_data_reg;
    logic [DW-1:0]                cur;
    logic                         wr_en;
    logic                         new_seen;
    logic signed [COORD_BITS-1:0] new_start;
    logic signed [COORD_BITS-1:0] new_end;
    logic                         near;

    // row extent
    logic                         any_reg;
    logic                         any_next;
    logic signed [COORD_BITS-1:0] min_row_reg;
    logic signed [COORD_BITS-1:0] min_row_next;
    logic signed [COORD_BITS-1:0] max_row_reg;
    logic signed [COORD_BITS-1:0] max_row_next;

    // result
    logic                         done_reg;
    logic                         in_range_reg;
    logic                         row_valid_reg;
    logic signed [COORD_BITS-1:0] span_start_reg;
    logic signed [COORD_BITS-1:0] span_end_reg;
    logic                         near_span_reg;
    logic signed [COORD_BITS-1:0] lowest_row_reg;
    logic signed [COORD_BITS-1:0] highest_row_reg;
    logic                         single_row_reg;

    assign busy      = clr_reg;
    assign cfg_ready = 1'b1;
    assign acc       = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_first_reg <= '0;
            row_last_reg  <= COORD_BITS'(ROW_LAST_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_FIRST: row_first_reg <= cfg_data;
                REG_ROW_LAST:  row_last_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // row index and window test
    assign diff   = {y[COORD_BITS-1], y} - {row_first_reg[COORD_BITS-1], row_first_reg};
    assign diff_w = {17'b0, diff};
    assign row_ok = (y >= row_first_reg) && (y <= row_last_reg) && (diff_w < CW'(ROWS));
    assign addr   = diff_w[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(ROWS - 1))
                clr_reg <= 1'b0;
        end
    end

    always_comb
    begin
        if (clr_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = s1_addr_reg;
            mem_wdata = {new_seen, new_start, new_end};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (acc)
            rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_op_reg    <= op;
            s1_x_reg     <= x;
            s1_y_reg     <= y;
            s1_ok_reg    <= row_ok;
            s1_addr_reg  <= addr;
            // the read above misses a write to the same row at this edge
            fwd_reg      <= wr_en && (s1_addr_reg == addr);
            fwd_data_reg <= mem_wdata;
        end
    end

    assign cur = fwd_reg ? fwd_data_reg : rd_data_reg;

    spext_update #(
        .COORD_BITS (COORD_BITS)
    ) u_update (
        .op        (s1_op_reg),
        .row_ok    (s1_valid_reg && s1_ok_reg),
        .x         (s1_x_reg),
        .cur_seen  (cur[DW-1]),
        .cur_start (cur[DW-2 -: COORD_BITS]),
        .cur_end   (cur[COORD_BITS-1:0]),
        .wr_en     (wr_en),
        .new_seen  (new_seen),
        .new_start (new_start),
        .new_end   (new_end),
        .near      (near)
    );

    always_comb
    begin
        any_next     = any_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        if (wr_en)
        begin
            any_next = 1'b1;
            if (!any_reg)
            begin
                min_row_next = s1_y_reg;
                max_row_next = s1_y_reg;
            end
            else
            begin
                if (s1_y_reg < min_row_reg)
                    min_row_next = s1_y_reg;
                if (s1_y_reg > max_row_reg)
                    max_row_next = s1_y_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg     <= 1'b0;
            min_row_reg <= '0;
            max_row_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            any_reg     <= any_next;
            min_row_reg <= min_row_next;
            max_row_reg <= max_row_next;
            done_reg    <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            in_range_reg    <= s1_ok_reg;
            row_valid_reg   <= s1_ok_reg && new_seen;
            span_start_reg  <= s1_ok_reg ? new_start : '0;
            span_end_reg    <= s1_ok_reg ? new_end : '0;
            near_span_reg   <= near;
            lowest_row_reg  <= min_row_next;
            highest_row_reg <= max_row_next;
            single_row_reg  <= (min_row_next == max_row_next);
        end
    end

    assign done        = done_reg;
    assign in_range    = in_range_reg;
    assign row_valid   = row_valid_reg;
    assign span_start  = span_start_reg;
    assign span_end    = span_end_reg;
    assign near_span   = near_span_reg;
    assign lowest_row  = lowest_row_reg;
    assign highest_row = highest_row_reg;
    assign single_row  = single_row_reg;

endmodule

// ===== sv/spext_update.sv =====
// ----------------------------------------------------------------------------
// Span update unit
// Merges a recorded point into a row entry and tests the point against the span
// widened by one column on each side.
// ----------------------------------------------------------------------------
module spext_update #(
    parameter int COORD_BITS = spext_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         op,
    input  logic                         row_ok,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic                         cur_seen,
    input  logic signed [COORD_BITS-1:0] cur_start,
    input  logic signed [COORD_BITS-1:0] cur_end,
    output logic                         wr_en,
    output logic                         new_seen,
    output logic signed [COORD_BITS-1:0] new_start,
    output logic signed [COORD_BITS-1:0] new_end,
    output logic                         near
);
    import spext_pkg::*;

    logic                         rec;
    logic signed [COORD_BITS:0]   x_lo;
    logic signed [COORD_BITS:0]   x_hi;
    logic signed [COORD_BITS:0]   st_w;
    logic signed [COORD_BITS:0]   en_w;

    assign rec   = row_ok && (op == OP_RECORD);
    assign wr_en = rec;

    always_comb
    begin
        new_seen  = cur_seen;
        new_start = cur_start;
        new_end   = cur_end;
        if (rec)
        begin
            new_seen = 1'b1;
            if (!cur_seen)
            begin
                new_start = x;
                new_end   = x;
            end
            else
            begin
                if (x < cur_start)
                    new_start = x;
                if (x > cur_end)
                    new_end = x;
            end
        end
    end

    // compare one bit wider so that x+1 and x-1 cannot wrap
    assign x_lo = {x[COORD_BITS-1], x} + (COORD_BITS+1)'(1);
    assign x_hi = {x[COORD_BITS-1], x} - (COORD_BITS+1)'(1);
    assign st_w = {new_start[COORD_BITS-1], new_start};
    assign en_w = {new_end[COORD_BITS-1], new_end};
    assign near = row_ok && (x_lo >= st_w) && (en_w >= x_hi);

endmodule

// ===== sv/spext_checker.sv =====
// ----------------------------------------------------------------------------
// Scanline span extent table: port checker
// Watches the core's ports for result timing and result consistency.
// ----------------------------------------------------------------------------
`include "scanline_span_extent_table_core_macros.svh"

module spext_checker #(
    parameter int COORD_BITS = spext_pkg::COORD_BITS_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         op,
    input logic                         done,
    input logic                         in_range,
    input logic                         row_valid,
    input logic signed [COORD_BITS-1:0] span_start,
    input logic signed [COORD_BITS-1:0] span_end,
    input logic                         near_span,
    input logic signed [COORD_BITS-1:0] lowest_row,
    input logic signed [COORD_BITS-1:0] highest_row,
    input logic                         single_row
);
    import spext_pkg::*;

    `SPEXT_ASSERT_NEXT(a_result_follows, start && !busy, ##1 done, "item without result")
    `SPEXT_ASSERT_NOW(a_no_stray_result, done, $past(start && !busy, 2), "result without item")
    `SPEXT_ASSERT_NOW(a_out_of_range_zero, done && !in_range,
        !row_valid && span_start == '0 && span_end == '0 && !near_span,
        "out-of-range row reports data")
    `SPEXT_ASSERT_NOW(a_record_marks_row,
        done && in_range && $past(start && !busy && op == OP_RECORD, 2),
        row_valid && span_start <= span_end, "recorded row not valid or span inverted")
    `SPEXT_ASSERT_NOW(a_single_row, done, single_row == (lowest_row == highest_row),
        "single_row disagrees with row extent")

endmodule

bind scanline_span_extent_table_core spext_checker #(
    .COORD_BITS (COORD_BITS)
) u_spext_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .done        (done),
    .in_range    (in_range),
    .row_valid   (row_valid),
    .span_start  (span_start),
    .span_end    (span_end),
    .near_span   (near_span),
    .lowest_row  (lowest_row),
    .highest_row (highest_row),
    .single_row  (single_row)
);
